[src/lifo_stack_engine_unit_assert.svh]
// Assertion macros for the checker file of the LIFO stack engine.
// Depends on nothing; the including module must have clock and reset signals.
`ifndef LIFO_STACK_ENGINE_UNIT_ASSERT_SVH
`define LIFO_STACK_ENGINE_UNIT_ASSERT_SVH

// Checked on every rising clock edge, switched off while reset is high.
`define LSE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define LSE_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

[src/lse_pkg.sv]
// Shared types and constants for the LIFO stack engine.
// Depends on nothing; used by the top level, its checker and the testbench.
package lse_pkg;

   localparam int DEPTH       = 16;
   localparam int ENTRY_WIDTH = 32;
   localparam int VAL_W       = 32;
   localparam int ACT_W       = 3;
   localparam int ERR_W       = 2;
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef enum logic [ACT_W-1:0] {
      ACT_PUSH     = 3'd0,
      ACT_POP      = 3'd1,
      ACT_PEEK     = 3'd2,
      ACT_CLEAR    = 3'd3,
      ACT_TRAVERSE = 3'd4
   } action_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_OK        = 2'd0,
      ERR_OVERFLOW  = 2'd1,
      ERR_UNDERFLOW = 2'd2
   } error_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_WALK
   } state_type;

endpackage

[src/lifo_stack_engine_unit.sv]
// LIFO stack engine: top level with the entry memory and the sequencer.
// Depends on lse_pkg.
//
// Usage. A transaction enters when start is high and busy is low; it carries
// an action (push, pop, peek, clear, traverse) and a push value. Each result
// transaction is shown for exactly one cycle with rsp_strobe high and is taken
// at the edge that ends that cycle; the receiver cannot stall, so no
// backpressure exists on the result side.
//
// Timing. Push, pop, peek, clear and unknown actions keep busy high only in the
// execute state and give their single result, registered, after it. A traverse
// over N entries keeps busy high through the execute and walk states and gives
// one result per cycle, top to bottom. The single read port of the entry
// memory, whose data is registered, sets this pace: one entry read per cycle.
// A new transaction may be accepted in the cycle that shows the previous
// transaction's last result.
//
// Reset (synchronous, active high) empties the stack and returns to idle. The
// entry memory is not cleared; only entries written by a push are ever reported.
module lifo_stack_engine_unit
   import lse_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [ACT_W-1:0] req_action,
   input  logic [VAL_W-1:0] req_push_value,
   output logic             rsp_strobe,
   output logic [VAL_W-1:0] rsp_out_value,
   output logic [CNT_W-1:0] rsp_entry_count,
   output logic             rsp_is_empty,
   output logic             rsp_is_full,
   output logic [ERR_W-1:0] rsp_error_code,
   output logic             rsp_last_of_run
);

   // Control state.
   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       walk_ff, walk_in;

   // Captured transaction.
   logic [ACT_W-1:0]       action_ff;
   logic [ENTRY_WIDTH-1:0] value_ff;

   // Entry memory with one write port and one registered read port.
   logic [ENTRY_WIDTH-1:0] mem [DEPTH];
   logic [ENTRY_WIDTH-1:0] rd_data_ff;
   logic [IDX_W-1:0]       rd_addr;
   logic [IDX_W-1:0]       wr_addr;
   logic                   mem_we;

   // Result registers.
   logic                   rsp_strobe_ff, rsp_strobe_in;
   logic [VAL_W-1:0]       rsp_value_ff, rsp_value_in;
   logic [CNT_W-1:0]       rsp_count_ff;
   logic                   rsp_empty_ff, rsp_full_ff;
   logic [ERR_W-1:0]       rsp_err_ff, rsp_err_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   accept;
   logic                   is_empty_now;
   logic                   is_full_now;
   logic [CNT_W-1:0]       count_m1;
   logic [CNT_W-1:0]       count_m2;
   logic [CNT_W-1:0]       walk_m2;

   assign busy         = (state_ff != ST_IDLE);
   assign accept       = start && !busy;
   assign is_empty_now = (count_ff == '0);
   assign is_full_now  = (count_ff == CNT_W'(DEPTH));
   assign count_m1     = count_ff - CNT_W'(1);
   assign count_m2     = count_ff - CNT_W'(2);
   assign walk_m2      = walk_ff - CNT_W'(2);
   assign wr_addr      = count_ff[IDX_W-1:0];

   // The read address always points at the entry that the next cycle emits:
   // the top while idle, and one entry further down during execution and walk.
   always_comb begin
      case (state_ff)
         ST_IDLE: rd_addr = count_m1[IDX_W-1:0];
         ST_EXEC: rd_addr = count_m2[IDX_W-1:0];
         ST_WALK: rd_addr = walk_m2[IDX_W-1:0];
         default: rd_addr = count_m1[IDX_W-1:0];
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if ((action_ff == ACT_TRAVERSE) && (count_ff > CNT_W'(1))) begin
               state_in = ST_WALK;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_WALK: begin
            if (walk_ff == CNT_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and result values.
   always_comb begin
      count_in      = count_ff;
      walk_in       = walk_ff;
      mem_we        = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_value_in  = '0;
      rsp_err_in    = ERR_OK;
      rsp_last_in   = 1'b1;
      case (state_ff)
         ST_EXEC: begin
            rsp_strobe_in = 1'b1;
            case (action_ff)
               ACT_PUSH: begin
                  if (is_full_now) begin
                     rsp_err_in = ERR_OVERFLOW;
                  end else begin
                     mem_we   = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                  end
               end
               ACT_POP: begin
                  if (is_empty_now) begin
                     rsp_err_in = ERR_UNDERFLOW;
                  end else begin
                     count_in     = count_m1;
                     rsp_value_in = VAL_W'(rd_data_ff);
                  end
               end
               ACT_PEEK: begin
                  if (is_empty_now) begin
                     rsp_err_in = ERR_UNDERFLOW;
                  end else begin
                     rsp_value_in = VAL_W'(rd_data_ff);
                  end
               end
               ACT_CLEAR: begin
                  count_in = '0;
               end
               ACT_TRAVERSE: begin
                  if (is_empty_now) begin
                     rsp_err_in = ERR_UNDERFLOW;
                  end else begin
                     rsp_value_in = VAL_W'(rd_data_ff);
                     rsp_last_in  = (count_ff == CNT_W'(1));
                     walk_in      = count_m1;
                  end
               end
               default: begin
                  // Unknown actions leave the stack alone and report its state.
               end
            endcase
         end
         ST_WALK: begin
            rsp_strobe_in = 1'b1;
            rsp_value_in  = VAL_W'(rd_data_ff);
            rsp_last_in   = (walk_ff == CNT_W'(1));
            walk_in       = walk_ff - CNT_W'(1);
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         walk_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         walk_ff       <= walk_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= req_action;
         value_ff  <= ENTRY_WIDTH'(req_push_value);
      end
      rsp_value_ff <= rsp_value_in;
      rsp_count_ff <= count_in;
      rsp_empty_ff <= (count_in == '0);
      rsp_full_ff  <= (count_in == CNT_W'(DEPTH));
      rsp_err_ff   <= rsp_err_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // Entry memory.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= value_ff;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_out_value   = rsp_value_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_is_empty    = rsp_empty_ff;
   assign rsp_is_full     = rsp_full_ff;
   assign rsp_error_code  = rsp_err_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule

[src/lse_checker.sv]
// Port-level checker for the LIFO stack engine, bound to the top level.
// Depends on lse_pkg and lifo_stack_engine_unit_assert.svh.
`include "lifo_stack_engine_unit_assert.svh"

module lse_checker
   import lse_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_strobe,
   input logic [CNT_W-1:0] rsp_entry_count,
   input logic             rsp_is_empty,
   input logic             rsp_is_full,
   input logic [ERR_W-1:0] rsp_error_code
);

   // An accepted transaction makes the block busy and is answered with a result strobe.
   `LSE_ASSERT(a_busy_after_accept, start && !busy |=> busy, "not busy after accept")
   `LSE_ASSERT(a_result_latency, start && !busy |=> ##1 rsp_strobe, "result missing")

   // The reported empty flag agrees with the reported count.
   `LSE_ASSERT(a_empty_flag, rsp_strobe |-> (rsp_is_empty == (rsp_entry_count == '0)), "empty flag wrong")

   // An overflow is only reported against a full stack.
   `LSE_ASSERT(a_overflow_full, rsp_strobe && (rsp_error_code == ERR_OVERFLOW) |-> rsp_is_full, "overflow not full")

   // Reset leaves the block idle with no result pending.
   `LSE_ASSERT_ALWAYS(a_reset_idle, reset |=> !busy && !rsp_strobe, "not idle after reset")

endmodule

bind lifo_stack_engine_unit lse_checker u_lse_checker (.*);

[tb/sv/lifo_stack_engine_unit_tb.sv]
// Self-checking testbench for the LIFO stack engine top level.
// Depends on lse_pkg and lifo_stack_engine_unit; it predicts every result
// transaction from its own stack model and checks each one as it is strobed.
module testbench;
   import lse_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Actions above traverse are not decoded by the block. It must ignore them
   // and still answer with a single result.
   localparam logic [ACT_W-1:0] ACT_SPARE_FIRST = ACT_W'(ACT_TRAVERSE + 1);
   localparam logic [ACT_W-1:0] ACT_SPARE_LAST  = {ACT_W{1'b1}};

   // This drain keeps watching after the last awaited result has arrived, so
   // that a stray late result still shows up.
   localparam int DRAIN_CYCLES = 16;

   // Idle chance in percent for each cycle on the request side.
   localparam int IDLE_PERCENT = 19;

   typedef struct {
      logic [VAL_W-1:0] out_value;
      logic [CNT_W-1:0] entry_count;
      logic             is_empty;
      logic             is_full;
      error_type        error_code;
      logic             last_of_run;
   } stack_result_type;

   // All inputs hold known values from time zero.
   logic             clock          = 1'b0;
   logic             reset          = 1'b1;
   logic             start          = 1'b0;
   logic [ACT_W-1:0] req_action     = '0;
   logic [VAL_W-1:0] req_push_value = '0;

   logic             busy;
   logic             rsp_strobe;
   logic [VAL_W-1:0] rsp_out_value;
   logic [CNT_W-1:0] rsp_entry_count;
   logic             rsp_is_empty;
   logic             rsp_is_full;
   logic [ERR_W-1:0] rsp_error_code;
   logic             rsp_last_of_run;

   lifo_stack_engine_unit DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_push_value  (req_push_value),
      .rsp_strobe      (rsp_strobe),
      .rsp_out_value   (rsp_out_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_is_full     (rsp_is_full),
      .rsp_error_code  (rsp_error_code),
      .rsp_last_of_run (rsp_last_of_run)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Hard stop in case the block hangs. The slowest correct run is a few
   // hundred transactions, each at most a full traverse plus an idle gap,
   // which is well under a tenth of this time.
   initial begin
      #500_000;
      $display("[lifo_stack_engine_unit] ERROR");
      $finish;
   end

   // ----------------------------------------------------------------------
   // Stack model. Its state moves forward at the edge where a request
   // transaction is accepted, and the results it produces are queued in the
   // order the block must strobe them.
   // ----------------------------------------------------------------------
   logic [ENTRY_WIDTH-1:0] shadow_entries [DEPTH];
   int                     shadow_count = 0;
   stack_result_type       awaited_results [$];

   bit gaps_enabled   = 1'b1;
   int fail_count     = 0;
   int items_sent     = 0;
   int results_seen   = 0;
   int overflow_hits  = 0;
   int underflow_hits = 0;
   int traverse_runs  = 0;

   // Queues one result that reflects the model count after the operation.
   task automatic queue_stack_result(input logic [VAL_W-1:0] value, input error_type err,
                                     input logic last);
      stack_result_type r;
      r.out_value   = value;
      r.entry_count = CNT_W'(shadow_count);
      r.is_empty    = (shadow_count == 0);
      r.is_full     = (shadow_count == DEPTH);
      r.error_code  = err;
      r.last_of_run = last;
      awaited_results.push_back(r);
      if (err == ERR_OVERFLOW) overflow_hits++;
      if (err == ERR_UNDERFLOW) underflow_hits++;
   endtask

   // Applies one accepted request to the model and queues what it causes.
   task automatic apply_stack_action(input logic [ACT_W-1:0] act,
                                     input logic [VAL_W-1:0] value);
      case (act)
         ACT_PUSH: begin
            if (shadow_count >= DEPTH) begin
               queue_stack_result('0, ERR_OVERFLOW, 1'b1);
            end else begin
               shadow_entries[shadow_count] = ENTRY_WIDTH'(value);
               shadow_count++;
               queue_stack_result('0, ERR_OK, 1'b1);
            end
         end
         ACT_POP: begin
            if (shadow_count == 0) begin
               queue_stack_result('0, ERR_UNDERFLOW, 1'b1);
            end else begin
               shadow_count--;
               queue_stack_result(VAL_W'(shadow_entries[shadow_count]), ERR_OK, 1'b1);
            end
         end
         ACT_PEEK: begin
            if (shadow_count == 0) begin
               queue_stack_result('0, ERR_UNDERFLOW, 1'b1);
            end else begin
               queue_stack_result(VAL_W'(shadow_entries[shadow_count - 1]), ERR_OK, 1'b1);
            end
         end
         ACT_CLEAR: begin
            shadow_count = 0;
            queue_stack_result('0, ERR_OK, 1'b1);
         end
         ACT_TRAVERSE: begin
            traverse_runs++;
            if (shadow_count == 0) begin
               queue_stack_result('0, ERR_UNDERFLOW, 1'b1);
            end else begin
               // Top entry first; only the bottom entry closes the run.
               for (int i = shadow_count - 1; i >= 0; i--) begin
                  queue_stack_result(VAL_W'(shadow_entries[i]), ERR_OK, i == 0);
               end
            end
         end
         default: begin
            queue_stack_result('0, ERR_OK, 1'b1);
         end
      endcase
   endtask

   // ----------------------------------------------------------------------
   // Request driver. Inputs change on the falling edge; acceptance is judged
   // from busy as it stood just before the rising edge. Start stays high
   // between back-to-back transactions, and while it is low the payload
   // ports carry random noise that the block must ignore.
   // ----------------------------------------------------------------------
   task automatic send_request(input logic [ACT_W-1:0] act, input logic [VAL_W-1:0] value);
      while (gaps_enabled && $urandom_range(0, 99) < IDLE_PERCENT) begin
         @(negedge clock);
         start          <= 1'b0;
         req_action     <= ACT_W'($urandom);
         req_push_value <= $urandom;
      end
      @(negedge clock);
      start          <= 1'b1;
      req_action     <= act;
      req_push_value <= value;
      @(posedge clock);
      while (busy) @(posedge clock);
      apply_stack_action(act, value);
      items_sent++;
   endtask

   // ----------------------------------------------------------------------
   // Result checker. A result transaction lives for one cycle only, so it is
   // compared at the rising edge that ends its strobe cycle.
   // ----------------------------------------------------------------------
   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      stack_result_type want;
      if (!reset && rsp_strobe) begin
         results_seen++;
         if (awaited_results.size() == 0) begin
            fail_count++;
            $display("%0t ns: unexpected result, expected none, actual value %0h count %0d",
                     $time, rsp_out_value, rsp_entry_count);
         end else begin
            want = awaited_results.pop_front();
            compare_field("out_value", 64'(want.out_value), 64'(rsp_out_value));
            compare_field("entry_count", 64'(want.entry_count), 64'(rsp_entry_count));
            compare_field("is_empty", 64'(want.is_empty), 64'(rsp_is_empty));
            compare_field("is_full", 64'(want.is_full), 64'(rsp_is_full));
            compare_field("error_code", 64'(want.error_code), 64'(rsp_error_code));
            compare_field("last_of_run", 64'(want.last_of_run), 64'(rsp_last_of_run));
         end
      end
   end

   // ----------------------------------------------------------------------
   // Tests.
   // ----------------------------------------------------------------------

   // Every action that reads the stack must report underflow when it is
   // empty; clear and a spare action must answer quietly with count zero.
   task automatic test_empty_stack;
      send_request(ACT_POP, $urandom);
      send_request(ACT_PEEK, $urandom);
      send_request(ACT_TRAVERSE, $urandom);
      send_request(ACT_CLEAR, $urandom);
      send_request(ACT_SPARE_LAST, $urandom);
   endtask

   // Fills the stack with extreme and patterned values, pushes once more to
   // provoke an overflow, walks the full stack, pops and peeks the top, then clears.
   task automatic test_fill_and_overflow;
      logic [VAL_W-1:0] patterns [6];
      patterns = '{'0, '1, {1'b1, {(VAL_W-1){1'b0}}}, VAL_W'(1),
                   {(VAL_W/2){2'b10}}, {(VAL_W/2){2'b01}}};
      for (int i = 0; i < DEPTH; i++) begin
         send_request(ACT_PUSH, (i < 6) ? patterns[i] : $urandom);
      end
      send_request(ACT_PUSH, $urandom);
      send_request(ACT_TRAVERSE, $urandom);
      send_request(ACT_POP, $urandom);
      send_request(ACT_PEEK, $urandom);
      send_request(ACT_CLEAR, $urandom);
   endtask

   // Random traffic that swings between filling and draining, so that the
   // stack keeps reaching both full and empty. Most transactions are regular
   // pushes, pops, peeks and walks; clears and spare actions are the noise.
   // Spare actions do not count toward the requested number.
   task automatic test_random_traffic(input int count);
      int               done    = 0;
      bit               filling = 1'b1;
      int               roll;
      logic [ACT_W-1:0] act;
      while (done < count) begin
         if (shadow_count == DEPTH) filling = 1'b0;
         else if (shadow_count == 0) filling = 1'b1;
         else if ($urandom_range(0, 99) < 5) filling = !filling;
         roll = $urandom_range(0, 99);
         if (roll < (filling ? 55 : 20))      act = ACT_PUSH;
         else if (roll < 68)                  act = ACT_POP;
         else if (roll < 80)                  act = ACT_PEEK;
         else if (roll < 92)                  act = ACT_TRAVERSE;
         else if (roll < 96)                  act = ACT_CLEAR;
         else act = ACT_W'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
         send_request(act, $urandom);
         if (act <= ACT_TRAVERSE) done++;
      end
   endtask

   // The same traffic with start held high throughout, so that requests meet
   // the block right at the end of each traverse and in every cycle between.
   task automatic test_back_to_back(input int count);
      gaps_enabled = 1'b0;
      test_random_traffic(count);
      gaps_enabled = 1'b1;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_stack();
      test_fill_and_overflow();
      test_random_traffic(300);
      test_back_to_back(90);

      // Let the pending results arrive, then keep watching a while for
      // anything the block emits beyond them.
      @(negedge clock);
      start <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d transactions with %0d traversals, %0d results checked.",
               items_sent, traverse_runs, results_seen);
      $display("Overflow results: %0d, underflow results: %0d, failures: %0d.",
               overflow_hits, underflow_hits, fail_count);
      if (fail_count == 0) begin
         $display("[lifo_stack_engine_unit] OK");
      end else begin
         $display("[lifo_stack_engine_unit] ERROR");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+src
src/lse_pkg.sv
src/lifo_stack_engine_unit.sv
src/lse_checker.sv
tb/sv/lifo_stack_engine_unit_tb.sv
